@@ hdl/owm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the 1-Wire bus master.
// No dependencies; used by owm_core and the top level.
package owm_pkg;

    localparam int CFG_W = 10;

    // Command kinds carried with each tick
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [2:0] CFG_RESET_REL    = 3'd1;
    localparam logic [2:0] CFG_PRES_WAIT    = 3'd2;
    localparam logic [2:0] CFG_PRES_LOW     = 3'd3;
    localparam logic [2:0] CFG_WR_ONE_LOW   = 3'd4;
    localparam logic [2:0] CFG_WR_ZERO_LOW  = 3'd5;
    localparam logic [2:0] CFG_RD_LOW       = 3'd6;
    localparam logic [2:0] CFG_RD_RECOVER   = 3'd7;

    // Register defaults after reset
    localparam logic [CFG_W-1:0] DEF_RESET_LOW   = 10'd750;
    localparam logic [CFG_W-1:0] DEF_RESET_REL   = 10'd15;
    localparam logic [CFG_W-1:0] DEF_PRES_WAIT   = 10'd100;
    localparam logic [CFG_W-1:0] DEF_PRES_LOW    = 10'd240;
    localparam logic [CFG_W-1:0] DEF_WR_ONE_LOW  = 10'd8;
    localparam logic [CFG_W-1:0] DEF_WR_ZERO_LOW = 10'd70;
    localparam logic [CFG_W-1:0] DEF_RD_LOW      = 10'd10;
    localparam logic [CFG_W-1:0] DEF_RD_RECOVER  = 10'd45;

    // Released time after the low part of a write slot
    localparam logic [7:0] WR_ONE_HIGH  = 8'd58;
    localparam logic [7:0] WR_ZERO_HIGH = 8'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       line_level;
    } t_in_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       no_device;
        logic       cmd_rejected;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_ticks;
        logic [CFG_W-1:0] reset_release_ticks;
        logic [CFG_W-1:0] presence_wait_limit;
        logic [CFG_W-1:0] presence_low_limit;
        logic [CFG_W-1:0] write_one_low_ticks;
        logic [CFG_W-1:0] write_zero_low_ticks;
        logic [CFG_W-1:0] read_low_ticks;
        logic [CFG_W-1:0] read_recover_ticks;
    } t_cfg_regs;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_RST_LOW   = 10'b00_0000_0010,
        PH_RST_REL   = 10'b00_0000_0100,
        PH_PRES_WAIT = 10'b00_0000_1000,
        PH_PRES_LOW  = 10'b00_0001_0000,
        PH_WR_LOW    = 10'b00_0010_0000,
        PH_WR_HIGH   = 10'b00_0100_0000,
        PH_RD_LOW    = 10'b00_1000_0000,
        PH_RD_SAMPLE = 10'b01_0000_0000,
        PH_RD_REC    = 10'b10_0000_0000
    } t_phase;

endpackage

@@ hdl/owm_core.sv @@
`timescale 1ns / 1ps
// Slot sequencer of the 1-Wire master: phase, tick timer, bit and byte state.
// Depends on owm_pkg. Advances one tick per accepted item.
module owm_core #(
    parameter int TIMER_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  owm_pkg::t_in_item  i_item,
    input  owm_pkg::t_cfg_regs i_cfg,
    output owm_pkg::t_out_item o_res
);

    localparam int CW = (TIMER_BITS > owm_pkg::CFG_W) ? TIMER_BITS : owm_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    owm_pkg::t_phase        r_phase,  n_phase;
    logic [TIMER_BITS-1:0]  r_timer,  n_timer;
    logic [2:0]             r_bit,    n_bit;
    logic [7:0]             r_shift,  n_shift;
    logic [7:0]             r_rdres,  n_rdres;
    logic                   r_absent, n_absent;

    logic                   done;
    logic                   drive;
    logic                   rej;
    logic [TIMER_BITS-1:0]  tm_inc;
    logic [CW-1:0]          cnt_limit;

    function automatic logic [TIMER_BITS-1:0] sat_load(input logic [owm_pkg::CFG_W-1:0] v);
        logic [CW-1:0] ve;
        ve = CW'(v);
        if (ve > CW'(TIMER_MAX))
            sat_load = TIMER_MAX;
        else
            sat_load = TIMER_BITS'(ve);
    endfunction

    // zero low time behaves as one tick
    function automatic logic [TIMER_BITS-1:0] low_len(input logic [owm_pkg::CFG_W-1:0] v);
        low_len = sat_load((v == '0) ? owm_pkg::CFG_W'(1) : v);
    endfunction

    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_rdres  = r_rdres;
        n_absent = r_absent;
        done     = 1'b0;
        drive    = 1'b0;
        rej      = 1'b0;

        // command start acts on this same tick
        if (r_phase == owm_pkg::PH_IDLE) begin
            case (i_item.kind)
                owm_pkg::KIND_RESET: begin
                    n_phase = owm_pkg::PH_RST_LOW;
                    n_timer = low_len(i_cfg.reset_low_ticks);
                end
                owm_pkg::KIND_WRITE: begin
                    n_shift = i_item.tx_byte;
                    n_bit   = 3'd0;
                    n_phase = owm_pkg::PH_WR_LOW;
                    n_timer = low_len(i_item.tx_byte[0] ? i_cfg.write_one_low_ticks
                                                        : i_cfg.write_zero_low_ticks);
                end
                owm_pkg::KIND_READ: begin
                    n_shift = 8'd0;
                    n_bit   = 3'd0;
                    n_phase = owm_pkg::PH_RD_LOW;
                    n_timer = low_len(i_cfg.read_low_ticks);
                end
                default: ;
            endcase
        end else if (i_item.kind != owm_pkg::KIND_TICK) begin
            rej = 1'b1;
        end

        // presence counter: raised first, then compared
        tm_inc    = (n_timer < TIMER_MAX) ? n_timer + 1'b1 : n_timer;
        cnt_limit = (n_phase == owm_pkg::PH_PRES_WAIT) ? CW'(i_cfg.presence_wait_limit)
                                                       : CW'(i_cfg.presence_low_limit);

        case (n_phase)
            owm_pkg::PH_IDLE: ;
            owm_pkg::PH_RST_LOW: begin
                drive = 1'b1;
                if (n_timer < TIMER_BITS'(2)) begin
                    n_timer = sat_load(i_cfg.reset_release_ticks);
                    n_phase = (n_timer == '0) ? owm_pkg::PH_PRES_WAIT : owm_pkg::PH_RST_REL;
                end else begin
                    n_timer = n_timer - 1'b1;
                end
            end
            owm_pkg::PH_RST_REL: begin
                if (n_timer < TIMER_BITS'(2)) begin
                    n_phase = owm_pkg::PH_PRES_WAIT;
                    n_timer = '0;
                end else begin
                    n_timer = n_timer - 1'b1;
                end
            end
            owm_pkg::PH_PRES_WAIT: begin
                if (!i_item.line_level) begin
                    n_phase = owm_pkg::PH_PRES_LOW;
                    n_timer = '0;
                end else begin
                    n_timer = tm_inc;
                    if (CW'(tm_inc) >= cnt_limit || tm_inc == TIMER_MAX) begin
                        n_absent = 1'b1;
                        n_phase  = owm_pkg::PH_IDLE;
                        n_timer  = '0;
                        done     = 1'b1;
                    end
                end
            end
            owm_pkg::PH_PRES_LOW: begin
                if (i_item.line_level) begin
                    n_absent = 1'b0;
                    n_phase  = owm_pkg::PH_IDLE;
                    n_timer  = '0;
                    done     = 1'b1;
                end else begin
                    n_timer = tm_inc;
                    if (CW'(tm_inc) >= cnt_limit || tm_inc == TIMER_MAX) begin
                        n_absent = 1'b1;
                        n_phase  = owm_pkg::PH_IDLE;
                        n_timer  = '0;
                        done     = 1'b1;
                    end
                end
            end
            owm_pkg::PH_WR_LOW: begin
                drive = 1'b1;
                if (n_timer < TIMER_BITS'(2)) begin
                    n_phase = owm_pkg::PH_WR_HIGH;
                    n_timer = TIMER_BITS'(n_shift[0] ? owm_pkg::WR_ONE_HIGH
                                                     : owm_pkg::WR_ZERO_HIGH);
                end else begin
                    n_timer = n_timer - 1'b1;
                end
            end
            owm_pkg::PH_WR_HIGH: begin
                if (n_timer < TIMER_BITS'(2)) begin
                    n_shift = {1'b0, n_shift[7:1]};
                    if (n_bit == 3'd7) begin
                        n_bit   = 3'd0;
                        n_phase = owm_pkg::PH_IDLE;
                        n_timer = '0;
                        done    = 1'b1;
                    end else begin
                        n_bit   = n_bit + 3'd1;
                        n_phase = owm_pkg::PH_WR_LOW;
                        n_timer = low_len(n_shift[0] ? i_cfg.write_one_low_ticks
                                                     : i_cfg.write_zero_low_ticks);
                    end
                end else begin
                    n_timer = n_timer - 1'b1;
                end
            end
            owm_pkg::PH_RD_LOW: begin
                drive = 1'b1;
                if (n_timer < TIMER_BITS'(2)) begin
                    n_phase = owm_pkg::PH_RD_SAMPLE;
                    n_timer = '0;
                end else begin
                    n_timer = n_timer - 1'b1;
                end
            end
            owm_pkg::PH_RD_SAMPLE, owm_pkg::PH_RD_REC: begin
                logic end_bit;
                end_bit = 1'b0;
                if (n_phase == owm_pkg::PH_RD_SAMPLE) begin
                    n_shift = {i_item.line_level, n_shift[7:1]};
                    n_timer = sat_load(i_cfg.read_recover_ticks);
                    if (n_timer == '0)
                        end_bit = 1'b1;
                    else
                        n_phase = owm_pkg::PH_RD_REC;
                end else if (n_timer < TIMER_BITS'(2)) begin
                    end_bit = 1'b1;
                end else begin
                    n_timer = n_timer - 1'b1;
                end
                if (end_bit) begin
                    if (n_bit == 3'd7) begin
                        n_rdres = n_shift;
                        n_bit   = 3'd0;
                        n_phase = owm_pkg::PH_IDLE;
                        n_timer = '0;
                        done    = 1'b1;
                    end else begin
                        n_bit   = n_bit + 3'd1;
                        n_phase = owm_pkg::PH_RD_LOW;
                        n_timer = low_len(i_cfg.read_low_ticks);
                    end
                end
            end
            default: n_phase = owm_pkg::PH_IDLE;
        endcase

        o_res.drive_low    = drive;
        o_res.busy_res     = (n_phase != owm_pkg::PH_IDLE);
        o_res.done_res     = done;
        o_res.rx_byte      = n_rdres;
        o_res.no_device    = n_absent;
        o_res.cmd_rejected = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= owm_pkg::PH_IDLE;
            r_timer  <= '0;
            r_bit    <= 3'd0;
            r_shift  <= 8'd0;
            r_rdres  <= 8'd0;
            r_absent <= 1'b0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_rdres  <= n_rdres;
            r_absent <= n_absent;
        end
    end

endmodule

@@ hdl/one_wire_master_slot_timing_top.sv @@
`timescale 1ns / 1ps
// Top level of the 1-Wire bus master: handshakes, register bank, result register.
// Depends on owm_pkg and owm_core.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | in        | i_in_valid/o_in_stall| i_in_item   (kind, tx_byte, line)
//  out     | out       | o_out_valid/i_out_stall | o_out_item (one per tick item)
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle while the input is not stalled: each accepted tick item updates
// the sequencer and loads the result register in the same cycle.
// The result register is the only buffer; the input stalls only while a result
// is held and the output is stalled. Synchronous active-low reset returns the
// master to idle with default timings. Config writes are always ready.
module one_wire_master_slot_timing_top #(
    parameter int TIMER_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  owm_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output owm_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [owm_pkg::CFG_W-1:0]     i_cfg_data
);

    owm_pkg::t_cfg_regs r_cfg;
    owm_pkg::t_out_item r_out_item;
    owm_pkg::t_out_item core_res;
    logic               r_out_valid;
    logic               adv;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign adv         = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    owm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks      <= owm_pkg::DEF_RESET_LOW;
            r_cfg.reset_release_ticks  <= owm_pkg::DEF_RESET_REL;
            r_cfg.presence_wait_limit  <= owm_pkg::DEF_PRES_WAIT;
            r_cfg.presence_low_limit   <= owm_pkg::DEF_PRES_LOW;
            r_cfg.write_one_low_ticks  <= owm_pkg::DEF_WR_ONE_LOW;
            r_cfg.write_zero_low_ticks <= owm_pkg::DEF_WR_ZERO_LOW;
            r_cfg.read_low_ticks       <= owm_pkg::DEF_RD_LOW;
            r_cfg.read_recover_ticks   <= owm_pkg::DEF_RD_RECOVER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                owm_pkg::CFG_RESET_LOW:   r_cfg.reset_low_ticks      <= i_cfg_data;
                owm_pkg::CFG_RESET_REL:   r_cfg.reset_release_ticks  <= i_cfg_data;
                owm_pkg::CFG_PRES_WAIT:   r_cfg.presence_wait_limit  <= i_cfg_data;
                owm_pkg::CFG_PRES_LOW:    r_cfg.presence_low_limit   <= i_cfg_data;
                owm_pkg::CFG_WR_ONE_LOW:  r_cfg.write_one_low_ticks  <= i_cfg_data;
                owm_pkg::CFG_WR_ZERO_LOW: r_cfg.write_zero_low_ticks <= i_cfg_data;
                owm_pkg::CFG_RD_LOW:      r_cfg.read_low_ticks       <= i_cfg_data;
                owm_pkg::CFG_RD_RECOVER:  r_cfg.read_recover_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_item <= core_res;
        end
    end

endmodule

@@ tb/tb_one_wire_master_slot_timing_top.sv @@
`timescale 1ns / 1ps
// Testbench for one_wire_master_slot_timing_top: drives tick items, predicts every result
// with a behavioural model of the bus master and checks each field in order.
// Depends on owm_pkg and the RTL of the master; needs nothing else.
module tb_one_wire_master_slot_timing_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    owm_pkg::t_in_item          i_in_item;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    owm_pkg::t_out_item         o_out_item;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [2:0]                 i_cfg_index;
    logic [owm_pkg::CFG_W-1:0]  i_cfg_data;

    one_wire_master_slot_timing_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model of the master
    owm_pkg::t_phase            mst_phase;
    logic [owm_pkg::CFG_W-1:0]  mst_timer;
    logic [2:0]                 bit_idx;
    logic [7:0]                 shift_reg;
    logic [7:0]                 rd_byte;
    logic                       absent;
    logic                       op_done;
    logic [owm_pkg::CFG_W-1:0]  timings [8];

    owm_pkg::t_out_item pending_results [$];
    int mismatch_cnt = 0;
    int sent_cnt = 0;
    int cycle_cnt = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    task reset_model();
        timings[owm_pkg::CFG_RESET_LOW]   = owm_pkg::DEF_RESET_LOW;
        timings[owm_pkg::CFG_RESET_REL]   = owm_pkg::DEF_RESET_REL;
        timings[owm_pkg::CFG_PRES_WAIT]   = owm_pkg::DEF_PRES_WAIT;
        timings[owm_pkg::CFG_PRES_LOW]    = owm_pkg::DEF_PRES_LOW;
        timings[owm_pkg::CFG_WR_ONE_LOW]  = owm_pkg::DEF_WR_ONE_LOW;
        timings[owm_pkg::CFG_WR_ZERO_LOW] = owm_pkg::DEF_WR_ZERO_LOW;
        timings[owm_pkg::CFG_RD_LOW]      = owm_pkg::DEF_RD_LOW;
        timings[owm_pkg::CFG_RD_RECOVER]  = owm_pkg::DEF_RD_RECOVER;
        mst_phase = owm_pkg::PH_IDLE;
        mst_timer = '0;
        bit_idx   = '0;
        shift_reg = '0;
        rd_byte   = '0;
        absent    = 1'b0;
        op_done   = 1'b0;
    endtask

    // a zero low time still gives one low tick
    function logic [owm_pkg::CFG_W-1:0] low_len(input logic [owm_pkg::CFG_W-1:0] v);
        return (v == '0) ? owm_pkg::CFG_W'(1) : v;
    endfunction

    function void end_op();
        mst_phase = owm_pkg::PH_IDLE;
        mst_timer = '0;
        op_done   = 1'b1;
    endfunction

    function void load_wr_low();
        mst_phase = owm_pkg::PH_WR_LOW;
        mst_timer = low_len(shift_reg[0] ? timings[owm_pkg::CFG_WR_ONE_LOW]
                                         : timings[owm_pkg::CFG_WR_ZERO_LOW]);
    endfunction

    function void load_rd_low();
        mst_phase = owm_pkg::PH_RD_LOW;
        mst_timer = low_len(timings[owm_pkg::CFG_RD_LOW]);
    endfunction

    function void end_rd_bit();
        if (bit_idx == 3'd7) begin
            rd_byte = shift_reg;
            bit_idx = '0;
            end_op();
        end else begin
            bit_idx++;
            load_rd_low();
        end
    endfunction

    // presence counters stop at the timer maximum, which also counts as running out
    function bit count_up(input logic [owm_pkg::CFG_W-1:0] limit);
        if (mst_timer != '1)
            mst_timer++;
        return (mst_timer >= limit) || (mst_timer == '1);
    endfunction

    task master_tick(input owm_pkg::t_in_item it, output owm_pkg::t_out_item res);
        logic drive;
        logic rej;
        drive   = 1'b0;
        rej     = 1'b0;
        op_done = 1'b0;
        if (mst_phase == owm_pkg::PH_IDLE) begin
            case (it.kind)
                owm_pkg::KIND_RESET: begin
                    mst_phase = owm_pkg::PH_RST_LOW;
                    mst_timer = low_len(timings[owm_pkg::CFG_RESET_LOW]);
                end
                owm_pkg::KIND_WRITE: begin
                    shift_reg = it.tx_byte;
                    bit_idx   = '0;
                    load_wr_low();
                end
                owm_pkg::KIND_READ: begin
                    shift_reg = '0;
                    bit_idx   = '0;
                    load_rd_low();
                end
                default: ;
            endcase
        end else if (it.kind != owm_pkg::KIND_TICK) begin
            rej = 1'b1;
        end

        case (mst_phase)
            owm_pkg::PH_RST_LOW: begin
                drive = 1'b1;
                if (mst_timer <= 1) begin
                    mst_timer = timings[owm_pkg::CFG_RESET_REL];
                    mst_phase = (mst_timer == '0) ? owm_pkg::PH_PRES_WAIT
                                                  : owm_pkg::PH_RST_REL;
                end else begin
                    mst_timer--;
                end
            end
            owm_pkg::PH_RST_REL: begin
                if (mst_timer <= 1) begin
                    mst_phase = owm_pkg::PH_PRES_WAIT;
                    mst_timer = '0;
                end else begin
                    mst_timer--;
                end
            end
            owm_pkg::PH_PRES_WAIT: begin
                if (!it.line_level) begin
                    mst_phase = owm_pkg::PH_PRES_LOW;
                    mst_timer = '0;
                end else if (count_up(timings[owm_pkg::CFG_PRES_WAIT])) begin
                    absent = 1'b1;
                    end_op();
                end
            end
            owm_pkg::PH_PRES_LOW: begin
                if (it.line_level) begin
                    absent = 1'b0;
                    end_op();
                end else if (count_up(timings[owm_pkg::CFG_PRES_LOW])) begin
                    absent = 1'b1;
                    end_op();
                end
            end
            owm_pkg::PH_WR_LOW: begin
                drive = 1'b1;
                if (mst_timer <= 1) begin
                    mst_phase = owm_pkg::PH_WR_HIGH;
                    mst_timer = shift_reg[0] ? owm_pkg::CFG_W'(owm_pkg::WR_ONE_HIGH)
                                             : owm_pkg::CFG_W'(owm_pkg::WR_ZERO_HIGH);
                end else begin
                    mst_timer--;
                end
            end
            owm_pkg::PH_WR_HIGH: begin
                if (mst_timer <= 1) begin
                    shift_reg = shift_reg >> 1;
                    if (bit_idx == 3'd7) begin
                        bit_idx = '0;
                        end_op();
                    end else begin
                        bit_idx++;
                        load_wr_low();
                    end
                end else begin
                    mst_timer--;
                end
            end
            owm_pkg::PH_RD_LOW: begin
                drive = 1'b1;
                if (mst_timer <= 1) begin
                    mst_phase = owm_pkg::PH_RD_SAMPLE;
                    mst_timer = '0;
                end else begin
                    mst_timer--;
                end
            end
            owm_pkg::PH_RD_SAMPLE: begin
                shift_reg = {it.line_level, shift_reg[7:1]};
                mst_timer = timings[owm_pkg::CFG_RD_RECOVER];
                if (mst_timer == '0)
                    end_rd_bit();
                else
                    mst_phase = owm_pkg::PH_RD_REC;
            end
            owm_pkg::PH_RD_REC: begin
                if (mst_timer <= 1)
                    end_rd_bit();
                else
                    mst_timer--;
            end
            default: mst_phase = owm_pkg::PH_IDLE;
        endcase

        res.drive_low    = drive;
        res.busy_res     = (mst_phase != owm_pkg::PH_IDLE);
        res.done_res     = op_done;
        res.rx_byte      = rd_byte;
        res.no_device    = absent;
        res.cmd_rejected = rej;
    endtask

    // Result checking
    function automatic bit field_ok(input string fname, input logic [7:0] want,
                                    input logic [7:0] got);
        if (got !== want) begin
            if (mismatch_cnt < 200)
                $error("%s: expected %0h, got %0h", fname, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        owm_pkg::t_out_item want;
        bit ok;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing outstanding");
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                ok = field_ok("drive_low", want.drive_low, o_out_item.drive_low)
                   & field_ok("busy_res", want.busy_res, o_out_item.busy_res)
                   & field_ok("done_res", want.done_res, o_out_item.done_res)
                   & field_ok("rx_byte", want.rx_byte, o_out_item.rx_byte)
                   & field_ok("no_device", want.no_device, o_out_item.no_device)
                   & field_ok("cmd_rejected", want.cmd_rejected, o_out_item.cmd_rejected);
                if (!ok)
                    mismatch_cnt++;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Called and returns at a falling edge; valid stays up until it is next driven
    task automatic send_item(input owm_pkg::t_in_item it);
        owm_pkg::t_out_item res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        master_tick(it, res);
        pending_results.push_back(res);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [owm_pkg::CFG_W-1:0] val);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        timings[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_timings(input int lo, input int hi);
        for (int r = 0; r < 8; r++)
            cfg_write(3'(r), owm_pkg::CFG_W'($urandom_range(hi, lo)));
    endtask

    // Ticks until the master goes idle. The simulated device pulls the line low after
    // pres_delay released samples and lets go after pres_len low samples.
    task automatic run_to_idle(input int pres_delay, input int pres_len, input int cmd_pct,
                               input bit noisy);
        owm_pkg::t_in_item it;
        int waited;
        int lowed;
        waited = 0;
        lowed  = 0;
        while (mst_phase != owm_pkg::PH_IDLE) begin
            if ($urandom_range(99) < cmd_pct)
                it.kind = 2'($urandom_range(3, 1));
            else
                it.kind = owm_pkg::KIND_TICK;
            it.tx_byte = 8'($urandom);
            case (mst_phase)
                owm_pkg::PH_PRES_WAIT: begin
                    it.line_level = (waited < pres_delay);
                    waited++;
                end
                owm_pkg::PH_PRES_LOW: begin
                    it.line_level = (lowed >= pres_len);
                    lowed++;
                end
                default: it.line_level = 1'($urandom_range(1));
            endcase
            if (noisy && $urandom_range(99) < 5)
                it.line_level = ~it.line_level;
            send_item(it);
        end
    endtask

    task automatic do_op(input logic [1:0] kind, input logic [7:0] txb, input int pres_delay,
                         input int pres_len, input int cmd_pct, input bit noisy);
        owm_pkg::t_in_item it;
        it.kind       = kind;
        it.tx_byte    = txb;
        it.line_level = 1'($urandom_range(1));
        send_item(it);
        run_to_idle(pres_delay, pres_len, cmd_pct, noisy);
    endtask

    // defaults after reset; only the reset low time and the read recovery time are changed
    task automatic test_default_timings();
        do_op(owm_pkg::KIND_TICK, 8'h00, 0, 0, 0, 0);
        cfg_write(owm_pkg::CFG_RESET_LOW, 10'd2);
        do_op(owm_pkg::KIND_RESET, 8'h00, 7, 20, 0, 0);
        cfg_write(owm_pkg::CFG_RD_RECOVER, 10'd0);
        do_op(owm_pkg::KIND_READ, 8'h00, 0, 0, 0, 0);
    endtask

    // zero low times act as one tick, zero release and recovery are skipped
    task automatic test_zero_timings();
        set_timings(0, 0);
        do_op(owm_pkg::KIND_RESET, 8'h00, 0, 0, 0, 0);
        do_op(owm_pkg::KIND_RESET, 8'h00, 1, 0, 0, 0);
        do_op(owm_pkg::KIND_RESET, 8'h00, 0, 1, 0, 0);
        do_op(owm_pkg::KIND_WRITE, 8'h01, 0, 0, 0, 0);
        do_op(owm_pkg::KIND_READ, 8'h00, 0, 0, 0, 0);
    endtask

    // full-scale presence limits; the device answers well inside them
    task automatic test_large_limits();
        set_timings(1, 2);
        cfg_write(owm_pkg::CFG_PRES_WAIT, 10'd1023);
        cfg_write(owm_pkg::CFG_PRES_LOW, 10'd1023);
        do_op(owm_pkg::KIND_RESET, 8'h00, 20, 15, 0, 0);
    endtask

    // every busy tick carries a command, the finishing tick included
    task automatic test_busy_commands();
        set_timings(1, 3);
        do_op(owm_pkg::KIND_RESET, 8'h00, 1, 2, 100, 0);
        do_op(owm_pkg::KIND_WRITE, 8'h00, 0, 0, 100, 0);
        do_op(owm_pkg::KIND_READ, 8'h00, 0, 0, 100, 0);
    endtask

    task automatic test_cfg_while_busy();
        owm_pkg::t_in_item it;
        set_timings(2, 5);
        it.kind       = owm_pkg::KIND_READ;
        it.tx_byte    = 8'h00;
        it.line_level = 1'b1;
        send_item(it);
        it.kind = owm_pkg::KIND_TICK;
        repeat (4) begin
            it.line_level = 1'($urandom_range(1));
            send_item(it);
        end
        cfg_write(owm_pkg::CFG_RD_RECOVER, 10'd1);
        cfg_write(owm_pkg::CFG_RD_LOW, 10'd3);
        run_to_idle(0, 0, 0, 0);
        it.kind = owm_pkg::KIND_RESET;
        send_item(it);
        cfg_write(owm_pkg::CFG_RESET_REL, 10'd0);
        cfg_write(owm_pkg::CFG_PRES_WAIT, 10'd2);
        run_to_idle(1, 1, 0, 0);
    endtask

    task automatic test_backpressure();
        set_timings(1, 4);
        hold_req++;
        do_op(owm_pkg::KIND_READ, 8'h00, 0, 0, 0, 0);
        do_op(owm_pkg::KIND_WRITE, 8'h00, 0, 0, 0, 0);
    endtask

    task automatic test_random_traffic();
        int idle_pcts [4];
        int stall_pcts [4];
        int phase_start;
        int sel;
        idle_pcts  = '{0, 49, 0, 31};
        stall_pcts = '{0, 0, 49, 31};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_pcts[p];
            stall_pct     = stall_pcts[p];
            set_timings(0, 4);
            phase_start = sent_cnt;
            while (sent_cnt - phase_start < 30) begin
                sel = $urandom_range(99);
                if (sel < 10)
                    do_op(owm_pkg::KIND_TICK, 8'($urandom), 0, 0, 0, 0);
                else if (sel < 50)
                    // presence timing around both limits, sometimes no device at all
                    do_op(owm_pkg::KIND_RESET, 8'($urandom),
                          ($urandom_range(4) == 0)
                              ? 5000
                              : $urandom_range(timings[owm_pkg::CFG_PRES_WAIT] + 1),
                          $urandom_range(timings[owm_pkg::CFG_PRES_LOW] + 1),
                          ($urandom_range(1) == 0) ? 0 : 4, $urandom_range(7) == 0);
                else if (sel < 85)
                    do_op(owm_pkg::KIND_READ, 8'($urandom), 0, 0,
                          ($urandom_range(1) == 0) ? 0 : 4, $urandom_range(7) == 0);
                else
                    // sparse ones keep the long write-one slots few
                    do_op(owm_pkg::KIND_WRITE,
                          8'($urandom) & 8'($urandom) & 8'($urandom), 0, 0,
                          ($urandom_range(1) == 0) ? 0 : 4, $urandom_range(7) == 0);
            end
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        reset_model();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_timings();
        test_zero_timings();
        test_large_limits();
        test_busy_commands();
        test_cfg_while_busy();
        test_backpressure();
        test_random_traffic();

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/owm_pkg.sv
hdl/owm_core.sv
hdl/one_wire_master_slot_timing_top.sv
tb/tb_one_wire_master_slot_timing_top.sv
